// ----- hw/rtl/luhn_pkg.sv -----
package luhn_pkg;

  localparam int MAX_DIGITS = 19;
  localparam int IN_W = 63;
  localparam int CNT_W = 5;
  localparam int SUM_W = 8;

  localparam logic [1:0] BRAND_NONE = 2'd0;
  localparam logic [1:0] BRAND_V    = 2'd1;
  localparam logic [1:0] BRAND_M    = 2'd2;
  localparam logic [1:0] BRAND_A    = 2'd3;

  // state carried along the digit pipeline
  typedef struct packed {
    logic [IN_W-1:0]  rest;
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
    logic [3:0]       lead;
    logic [6:0]       pair;
  } dig_t;

  // doubled digit with its decimal digits summed
  function automatic logic [3:0] dbl_fold(input logic [3:0] d);
    logic [4:0] t;
    t = {d, 1'b0};
    if (t >= 5'd10) t = t - 5'd9;
    return t[3:0];
  endfunction

endpackage

// ----- hw/rtl/luhn_stage.sv -----
// one digit peeled per stage, registered in qc_r and mid_r and then in d_out: divide by ten with shifts and adds
module luhn_stage
  import luhn_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  vld_in,
  input  dig_t  d_in,
  output logic  vld_out,
  output dig_t  d_out
);

  logic [IN_W-1:0] qa;
  logic [IN_W-1:0] qb;
  logic [IN_W-1:0] qc;
  logic [IN_W-1:0] qc_r;
  dig_t            mid_r;
  logic            vld_mid_r;
  logic [IN_W-1:0] qd;
  logic [IN_W-1:0] qe;
  logic [IN_W-1:0] q0;
  logic [IN_W-1:0] rr;
  logic [IN_W-1:0] q;
  logic [3:0]      r;
  logic            nz;
  dig_t            d_nxt;

  // first half: start of the 0.8 * n series
  always_comb begin
    qa = (d_in.rest >> 1) + (d_in.rest >> 2);
    qb = qa + (qa >> 4);
    qc = qb + (qb >> 8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_mid_r <= 1'b0;
    end else if (en) begin
      vld_mid_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qc_r  <= qc;
      mid_r <= d_in;
    end
  end

  // second half: quotient estimate is low by at most one, fix it up
  always_comb begin
    qd    = qc_r + (qc_r >> 16);
    qe    = qd + (qd >> 32);
    q0    = qe >> 3;
    rr    = mid_r.rest - ((q0 << 3) + (q0 << 1));
    if (rr > IN_W'(9)) begin
      q = q0 + IN_W'(1);
      r = 4'(rr - IN_W'(10));
    end else begin
      q = q0;
      r = 4'(rr);
    end
    nz    = (mid_r.rest != '0);
    d_nxt = mid_r;
    if (nz) begin
      d_nxt.rest  = q;
      d_nxt.count = mid_r.count + CNT_W'(1);
      d_nxt.sum   = mid_r.sum + SUM_W'(mid_r.count[0] ? dbl_fold(r) : r);
      d_nxt.pair  = 7'(r) * 7'd10 + 7'(mid_r.lead);
      d_nxt.lead  = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_mid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_nxt;
    end
  end

endmodule

// ----- hw/rtl/luhn_classify.sv -----
// mod-ten test and issuer classification, registered
module luhn_classify
  import luhn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_in,
  input  dig_t             d_in,
  output logic             vld_out,
  output logic [1:0]       brand,
  output logic             luhn_valid,
  output logic [CNT_W-1:0] digit_count,
  output logic [SUM_W-1:0] luhn_sum,
  output logic [3:0]       leading_digit,
  output logic [6:0]       leading_pair
);

  logic [15:0]      prod;
  logic [4:0]       qt;
  logic [SUM_W-1:0] m;
  logic             ok;
  logic [1:0]       b;
  logic [6:0]       pr;

  always_comb begin
    // remainder by ten through the reciprocal 205 / 2048, exact for the sum range
    prod = 16'(d_in.sum) * 16'd205;
    qt   = prod[15:11];
    m    = d_in.sum - SUM_W'(qt) * SUM_W'(10);
    ok   = (m == '0);
    pr = (d_in.count >= CNT_W'(2)) ? d_in.pair : 7'(d_in.lead);
    b  = BRAND_NONE;
    if (ok) begin
      if (d_in.count == CNT_W'(16)) begin
        if (d_in.lead == 4'd4) b = BRAND_V;
        else if (pr >= 7'd51 && pr <= 7'd55) b = BRAND_M;
      end else if (d_in.count == CNT_W'(15)) begin
        if (pr == 7'd34 || pr == 7'd37) b = BRAND_A;
      end else if (d_in.count == CNT_W'(13)) begin
        if (d_in.lead == 4'd4) b = BRAND_V;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      brand         <= b;
      luhn_valid    <= ok;
      digit_count   <= d_in.count;
      luhn_sum      <= d_in.sum;
      leading_digit <= d_in.lead;
      leading_pair  <= pr;
    end
  end

endmodule

// ----- hw/rtl/luhn_card_number_check_top.sv -----
// luhn card number check
// input channel: in_card_number (63-bit unsigned binary) with in_valid/in_ready;
// a transfer happens when valid and ready are both high
// result channel: out_brand, out_luhn_valid, out_digit_count, out_luhn_sum,
// out_leading_digit, out_leading_pair with out_valid/out_ready
// structure: 19 digit stages, each peels one decimal digit over two register
// steps with a shift-and-add divide by ten, then one classification stage
// throughput: one item per cycle unless out_ready holds the pipeline; the depth of the digit pipeline sets latency
// stall: when the result waits and out_ready is low the whole pipeline holds,
// nothing is lost or repeated; bubbles inside the pipeline are not squeezed out
// reset: synchronous active-low rst_n clears all valid bits, pipeline empties
module luhn_card_number_check_top
  import luhn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IN_W-1:0]  in_card_number,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_brand,
  output logic             out_luhn_valid,
  output logic [CNT_W-1:0] out_digit_count,
  output logic [SUM_W-1:0] out_luhn_sum,
  output logic [3:0]       out_leading_digit,
  output logic [6:0]       out_leading_pair
);

  logic en;
  logic vld [MAX_DIGITS+1];
  dig_t dg  [MAX_DIGITS+1];

  // advance whenever the output slot is empty or being taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign vld[0] = in_valid;
  always_comb begin
    dg[0]       = '0;
    dg[0].rest  = in_card_number;
  end

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_dig
    luhn_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (vld[i]),
      .d_in    (dg[i]),
      .vld_out (vld[i+1]),
      .d_out   (dg[i+1])
    );
  end

  luhn_classify u_cls (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .vld_in        (vld[MAX_DIGITS]),
    .d_in          (dg[MAX_DIGITS]),
    .vld_out       (out_valid),
    .brand         (out_brand),
    .luhn_valid    (out_luhn_valid),
    .digit_count   (out_digit_count),
    .luhn_sum      (out_luhn_sum),
    .leading_digit (out_leading_digit),
    .leading_pair  (out_leading_pair)
  );

endmodule
